FILE: rtl/core/rlp_pkg.sv
// Shared constants and types for the range-list text parser.
package rlp_pkg;

  localparam int MAX_DIGITS = 12;
  localparam int TEXT_W     = 8;
  localparam int VAL_W      = 40;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  localparam logic [TEXT_W-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [TEXT_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [TEXT_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [TEXT_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef struct packed {
    logic [VAL_W-1:0] range_base;
    logic [VAL_W-1:0] range_count;
    logic             parse_error;
    logic             from_final_char;
  } rlp_res_t;

  // Handoff of one result word from the parser to the output buffer.
  typedef struct packed {
    logic     valid;
    rlp_res_t res;
  } rlp_res_word_t;

endpackage

FILE: rtl/core/rlp_if.sv
// Valid/ready channel interfaces for the character and result words.
interface rlp_in_if
  import rlp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TEXT_W-1:0] text_char;
  logic              final_char;

  modport source(output valid, text_char, final_char, input ready);
  modport sink(input valid, text_char, final_char, output ready);
endinterface

interface rlp_out_if
  import rlp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] range_base;
  logic [VAL_W-1:0] range_count;
  logic             parse_error;
  logic             from_final_char;

  modport source(output valid, range_base, range_count, parse_error, from_final_char,
                 input ready);
  modport sink(input valid, range_base, range_count, parse_error, from_final_char,
               output ready);
endinterface

FILE: rtl/core/rlp_parse.sv
// Input register, parser state and per-character next-state and result logic.
module rlp_parse
  import rlp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  rlp_in_if.sink        in_ch,
  output rlp_res_word_t res_word,
  input  logic          res_ready
);

  logic              ir_valid;
  logic [TEXT_W-1:0] ir_char;
  logic              ir_final;

  logic [VAL_W-1:0] digit_value;
  logic [CNT_W-1:0] digit_count;
  logic [VAL_W-1:0] range_low_end;
  logic             awaiting_first;
  logic             halted;

  logic [VAL_W-1:0] digit_value_next;
  logic [CNT_W-1:0] digit_count_next;
  logic [VAL_W-1:0] range_low_end_next;
  logic             awaiting_first_next;
  logic             halted_next;

  logic             is_dash, is_comma, is_digit, take_digit;
  logic [3:0]       digit;
  logic [VAL_W-1:0] acc_value;
  logic [CNT_W-1:0] mid_count;
  logic [VAL_W-1:0] end_a, end_b, lo, hi, diff;
  logic [VAL_W:0]   cnt_wide;
  logic             emit, err, produce, fire;
  rlp_res_t         res;

  assign is_dash    = (ir_char == CHAR_DASH);
  assign is_comma   = (ir_char == CHAR_COMMA);
  assign is_digit   = (ir_char >= CHAR_ZERO) && (ir_char <= CHAR_NINE);
  assign take_digit = is_digit && (digit_count < CNT_W'(MAX_DIGITS));
  assign digit      = 4'(ir_char - CHAR_ZERO);

  // Times ten as two shifts and an add, wrapping at the value width.
  assign acc_value = (digit_value << 3) + (digit_value << 1) + VAL_W'(digit);

  always_comb begin
    if (is_dash) begin
      mid_count = '0;
    end else if (take_digit) begin
      mid_count = digit_count + CNT_W'(1);
    end else begin
      mid_count = digit_count;
    end
  end

  // One emit path serves both the comma and the end of the text.
  assign end_b    = take_digit ? acc_value : digit_value;
  assign end_a    = awaiting_first ? end_b : range_low_end;
  assign lo       = (end_a < end_b) ? end_a : end_b;
  assign hi       = (end_a < end_b) ? end_b : end_a;
  assign diff     = hi - lo;
  assign cnt_wide = {1'b0, diff} + (VAL_W+1)'(1);

  assign err  = !halted && is_comma && (digit_count == '0);
  assign emit = !halted && ((is_comma && (digit_count != '0)) ||
                            (ir_final && !is_comma && (mid_count != '0)));
  assign produce = ir_valid && (err || emit);

  always_comb begin
    res.range_base      = err ? '0 : lo;
    res.range_count     = err ? '0 : (cnt_wide[VAL_W] ? VAL_MAX : cnt_wide[VAL_W-1:0]);
    res.parse_error     = err;
    res.from_final_char = ir_final;
  end

  assign res_word.valid = produce;
  assign res_word.res   = res;

  // A word that gives no result moves on even while the output is stalled.
  assign fire        = ir_valid && (!produce || res_ready);
  assign in_ch.ready = !ir_valid || fire;

  always_comb begin
    digit_value_next    = digit_value;
    digit_count_next    = digit_count;
    range_low_end_next  = range_low_end;
    awaiting_first_next = awaiting_first;
    halted_next         = halted;
    if (ir_final) begin
      digit_value_next    = '0;
      digit_count_next    = '0;
      range_low_end_next  = '0;
      awaiting_first_next = 1'b1;
      halted_next         = 1'b0;
    end else if (!halted) begin
      if (is_dash) begin
        range_low_end_next  = digit_value;
        awaiting_first_next = 1'b0;
        digit_value_next    = '0;
        digit_count_next    = '0;
      end else if (is_comma) begin
        if (err) begin
          halted_next = 1'b1;
        end else begin
          digit_value_next    = '0;
          digit_count_next    = '0;
          awaiting_first_next = 1'b1;
        end
      end else if (take_digit) begin
        digit_value_next = acc_value;
        digit_count_next = mid_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ch.ready) begin
      ir_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      ir_char  <= in_ch.text_char;
      ir_final <= in_ch.final_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_value    <= '0;
      digit_count    <= '0;
      range_low_end  <= '0;
      awaiting_first <= 1'b1;
      halted         <= 1'b0;
    end else if (fire) begin
      digit_value    <= digit_value_next;
      digit_count    <= digit_count_next;
      range_low_end  <= range_low_end_next;
      awaiting_first <= awaiting_first_next;
      halted         <= halted_next;
    end
  end

`ifndef SYNTHESIS
  a_halt_no_digits: assert property (@(posedge clk) disable iff (rst)
    halted |-> (digit_count == '0))
    else $error("parser halted with digits pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_W'(MAX_DIGITS))
    else $error("digit count above limit");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    fire && ir_final |=> awaiting_first && !halted && (digit_count == '0))
    else $error("state not cleared after final character");

  a_range_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_word.valid && !res_word.res.parse_error |-> (res_word.res.range_count != '0))
    else $error("range result with zero count");
`endif

endmodule

FILE: rtl/core/rlp_out_buf.sv
// Output register that holds one result word until the sink takes it.
module rlp_out_buf
  import rlp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  rlp_res_word_t res_word,
  output logic          res_ready,
  rlp_out_if.source     out_ch
);

  logic     valid;
  rlp_res_t res;

  assign res_ready = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_word.valid;
    end
    if (res_ready && res_word.valid) begin
      res <= res_word.res;
    end
  end

  assign out_ch.valid           = valid;
  assign out_ch.range_base      = res.range_base;
  assign out_ch.range_count     = res.range_count;
  assign out_ch.parse_error     = res.parse_error;
  assign out_ch.from_final_char = res.from_final_char;

`ifndef SYNTHESIS
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    valid && res.parse_error |-> (res.range_base == '0) && (res.range_count == '0))
    else $error("error word carries a range");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res_word.valid && res_ready |=> valid)
    else $error("result word lost at output register");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    valid && out_ch.ready && !res_word.valid |=> !valid)
    else $error("result word repeated");
`endif

endmodule

FILE: rtl/core/range_list_text_parser.sv
// Top level of the range-list text parser: input stage, parser and output register.
//
//   channel  dir  payload                                              word
//   in_ch    in   text_char[7:0], final_char                           one character
//   out_ch   out  range_base[39:0], range_count[39:0], parse_error,    one range or error
//                 from_final_char
//
// One character word is accepted per cycle unless a result waits on a stalled out_ch; its
// result is offered on out_ch once it has passed the input register, then the output register.
// The digit accumulate, end compare and count subtract sit between those two registers.
// rst (synchronous) empties both registers and clears the parser state.
// While out_ch is stalled with a full output register, characters that give no result
// still pass; a character that gives one waits in the input register.
module range_list_text_parser
  import rlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  rlp_in_if.sink    in_ch,
  rlp_out_if.source out_ch
);

  rlp_res_word_t res_word;
  logic          res_ready;

  rlp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .res_word  (res_word),
    .res_ready (res_ready)
  );

  rlp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_word  (res_word),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the range-list text parser with a built-in result predictor.
`timescale 1ns / 100ps

module tb_top;
  import rlp_pkg::*;

  typedef struct {
    logic [TEXT_W-1:0] ch;
    logic              fin;
  } char_word_t;

  logic clk = 1'b0;
  logic rst;

  rlp_in_if  char_ch();
  rlp_out_if range_ch();

  range_list_text_parser DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (char_ch),
    .out_ch (range_ch)
  );

  always #5 clk = ~clk;

  char_word_t pending_chars[$];
  rlp_res_t   expected_ranges[$];
  int         pushed_total = 0;
  int         useful_chars = 0;
  int         accepted = 0;
  int         errors = 0;
  int         hold_left = 0;
  int         next_hold_at = 300;
  logic       quiet;

  // Predictor state: mirrors the parser's number and range registers.
  logic [VAL_W-1:0] acc_value = '0;
  logic [CNT_W-1:0] acc_digits = '0;
  logic [VAL_W-1:0] low_end = '0;
  logic             wait_first = 1'b1;
  logic             stopped = 1'b0;

  // Neither side idles while this window of accepted words is active.
  assign quiet = (accepted >= 500) && (accepted < 800);

  function automatic rlp_res_t close_range();
    rlp_res_t         r;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W:0]   cnt;
    r = '0;
    a = wait_first ? acc_value : low_end;
    if (a < acc_value) begin
      lo = a;
      hi = acc_value;
    end else begin
      lo = acc_value;
      hi = a;
    end
    cnt = {1'b0, hi} - {1'b0, lo} + (VAL_W+1)'(1);
    r.range_base  = lo;
    r.range_count = cnt[VAL_W] ? VAL_MAX : cnt[VAL_W-1:0];
    acc_value  = '0;
    acc_digits = '0;
    wait_first = 1'b1;
    return r;
  endfunction

  task automatic predict_char(input logic [TEXT_W-1:0] ch, input logic fin);
    rlp_res_t r;
    logic     produced;
    r = '0;
    produced = 1'b0;
    if (!stopped) begin
      if (ch == CHAR_DASH) begin
        low_end    = acc_value;
        wait_first = 1'b0;
        acc_value  = '0;
        acc_digits = '0;
      end else if (ch == CHAR_COMMA) begin
        if (acc_digits == 0) begin
          r.parse_error = 1'b1;
          stopped = 1'b1;
        end else begin
          r = close_range();
        end
        r.from_final_char = fin;
        produced = 1'b1;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        if (acc_digits < MAX_DIGITS) begin
          acc_value  = acc_value * VAL_W'(10) + VAL_W'(ch - CHAR_ZERO);
          acc_digits = acc_digits + 1'b1;
        end
      end
      // The end of the text flushes a range whose digits are still pending.
      if (fin && !produced && acc_digits != 0) begin
        r = close_range();
        r.from_final_char = 1'b1;
        produced = 1'b1;
      end
    end
    if (produced)
      expected_ranges.push_back(r);
    if (fin) begin
      acc_value  = '0;
      acc_digits = '0;
      low_end    = '0;
      wait_first = 1'b1;
      stopped    = 1'b0;
    end
  endtask

  task automatic push_char(input logic [TEXT_W-1:0] ch, input logic fin);
    char_word_t w;
    w.ch  = ch;
    w.fin = fin;
    pending_chars.push_back(w);
    pushed_total++;
    if (fin || ch == CHAR_DASH || ch == CHAR_COMMA || (ch >= CHAR_ZERO && ch <= CHAR_NINE))
      useful_chars++;
  endtask

  task automatic push_string(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], fin_last && (i == s.len() - 1));
  endtask

  task automatic add_number(ref logic [TEXT_W-1:0] txt[$]);
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 5)
      len = 0;
    else if (pick < 75)
      len = $urandom_range(4, 1);
    else if (pick < 90)
      len = $urandom_range(11, 5);
    else
      len = $urandom_range(14, 12);
    for (int i = 0; i < len; i++)
      txt.push_back(CHAR_ZERO + TEXT_W'($urandom_range(9)));
  endtask

  // Driver: offers the next pending word, holding it until the parser takes it.
  always @(posedge clk) begin : drive_chars
    char_word_t w;
    if (rst) begin
      char_ch.valid <= 1'b0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        predict_char(char_ch.text_char, char_ch.final_char);
        accepted <= accepted + 1;
      end
      if (!char_ch.valid || char_ch.ready) begin
        if (pending_chars.size() != 0 && (quiet || $urandom_range(99) >= 37)) begin
          w = pending_chars.pop_front();
          char_ch.valid      <= 1'b1;
          char_ch.text_char  <= w.ch;
          char_ch.final_char <= w.fin;
        end else begin
          char_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word and drives ready, with two long hold-offs.
  always @(posedge clk) begin : check_ranges
    rlp_res_t got;
    rlp_res_t want;
    if (rst) begin
      range_ch.ready <= 1'b0;
    end else begin
      if (range_ch.valid && range_ch.ready) begin
        got = '{range_base: range_ch.range_base, range_count: range_ch.range_count,
                parse_error: range_ch.parse_error, from_final_char: range_ch.from_final_char};
        if (expected_ranges.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %p", $time, got);
          errors++;
        end else begin
          want = expected_ranges.pop_front();
          if (got.range_base !== want.range_base) begin
            $display("%0t: range_base expected %0d actual %0d", $time,
                     want.range_base, got.range_base);
            errors++;
          end
          if (got.range_count !== want.range_count) begin
            $display("%0t: range_count expected %0d actual %0d", $time,
                     want.range_count, got.range_count);
            errors++;
          end
          if (got.parse_error !== want.parse_error) begin
            $display("%0t: parse_error expected %0b actual %0b", $time,
                     want.parse_error, got.parse_error);
            errors++;
          end
          if (got.from_final_char !== want.from_final_char) begin
            $display("%0t: from_final_char expected %0b actual %0b", $time,
                     want.from_final_char, got.from_final_char);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        range_ch.ready <= 1'b0;
      end else if (accepted >= next_hold_at) begin
        hold_left <= 400;
        next_hold_at <= (next_hold_at == 300) ? 1000 : 32'h7FFF_FFFF;
        range_ch.ready <= 1'b0;
      end else begin
        range_ch.ready <= quiet || ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin : stimulus
    logic [TEXT_W-1:0] txt[$];
    int                kind;
    int                n_ranges;
    int                cut;
    rst = 1'b1;

    // Fourteen nines keep only twelve; the range to zero has the largest count.
    push_string("99999999999999-0", 1'b1);
    // Dash with no digits, repeated dash, then a comma after the dash halts;
    // the final word arrives while halted and emits nothing.
    push_string("-3-,", 1'b0);
    push_char(8'hFF, 1'b1);
    // Plain range closed by a comma, an ignored zero byte, text ending on a dash.
    push_string("2,", 1'b0);
    push_char(8'h00, 1'b0);
    push_string("5-", 1'b1);

    while (useful_chars < 1350) begin
      kind = $urandom_range(99);
      txt.delete();
      if (kind < 75) begin
        n_ranges = $urandom_range(5, 1);
        for (int i = 0; i < n_ranges; i++) begin
          if ($urandom_range(7) == 0)
            txt.push_back(TEXT_W'($urandom_range(255)));
          add_number(txt);
          if ($urandom_range(1) == 0) begin
            txt.push_back(CHAR_DASH);
            add_number(txt);
          end
          if (i != n_ranges - 1 || $urandom_range(5) == 0)
            txt.push_back(CHAR_COMMA);
        end
        // Sometimes the text is cut short at a random point.
        if ($urandom_range(9) == 0 && txt.size() > 1) begin
          cut = $urandom_range(txt.size() - 1, 1);
          while (txt.size() > cut)
            void'(txt.pop_back());
        end
      end else if (kind < 90) begin
        n_ranges = $urandom_range(10, 1);
        for (int i = 0; i < n_ranges; i++) begin
          case ($urandom_range(3))
            0: txt.push_back(CHAR_ZERO + TEXT_W'($urandom_range(9)));
            1: txt.push_back(CHAR_DASH);
            2: txt.push_back(CHAR_COMMA);
            default: txt.push_back(TEXT_W'($urandom_range(255)));
          endcase
        end
      end else begin
        push_char(TEXT_W'($urandom_range(255)), $urandom_range(7) == 0);
      end
      for (int i = 0; i < txt.size(); i++)
        push_char(txt[i], i == txt.size() - 1);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (accepted < pushed_total)
      @(posedge clk);
    while (expected_ranges.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rlp_pkg.sv
rtl/core/rlp_if.sv
rtl/core/rlp_parse.sv
rtl/core/rlp_out_buf.sv
rtl/core/range_list_text_parser.sv
dv/tb_top.sv
